>>> design/ansi_text_cursor_engine_macros.svh
// ----------------------------------------------------------------------------
// ansi text cursor engine assertion macros
// shared property forms for the cursor engine checks, clocked on i_clk and
// held off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef ANSI_TEXT_CURSOR_ENGINE_MACROS_SVH
`define ANSI_TEXT_CURSOR_ENGINE_MACROS_SVH

// same-cycle implication
`define ATCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ATCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/atce_pkg.sv
// ----------------------------------------------------------------------------
// atce_pkg
// types, character codes, register indexes and colours of the cursor engine
// ----------------------------------------------------------------------------
package atce_pkg;

    localparam int DEFAULT_MAX_PARAMS = 8;

    localparam int CHAR_W  = 8;
    localparam int PARAM_W = 14;
    localparam int POS_W   = 24;
    localparam int COLOR_W = 32;
    localparam int SCALE_W = 4;
    localparam int GH_W    = 5;
    localparam int GC_W    = 9;
    localparam int DIM_W   = 14;
    localparam int CELLW_W = 7;
    localparam int CELLH_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 14;
    localparam int TDATA_W = 120;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FONT_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_ROW      = 3'd5;

    // register reset values
    localparam logic [SCALE_W-1:0] RST_FONT_SCALE   = 4'd1;
    localparam logic [GH_W-1:0]    RST_GLYPH_HEIGHT = 5'd8;
    localparam logic [GC_W-1:0]    RST_GLYPH_COUNT  = 9'd128;
    localparam logic [DIM_W-1:0]   RST_SCREEN_W     = 14'd1024;
    localparam logic [DIM_W-1:0]   RST_SCREEN_H     = 14'd768;
    localparam logic [DIM_W-1:0]   RST_TOP_ROW      = 14'd0;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_ESC   = 8'h1B;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CHAR_QMARK = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_FIN_H = 8'h48;
    localparam logic [CHAR_W-1:0] CHAR_FIN_J = 8'h4A;
    localparam logic [CHAR_W-1:0] CHAR_LBRK  = 8'h5B;
    localparam logic [CHAR_W-1:0] CHAR_FIN_M = 8'h6D;

    localparam logic [PARAM_W-1:0] PARAM_CAP  = 14'd9999;
    localparam logic [PARAM_W-1:0] PARAM_TWO  = 14'd2;

    // sgr codes
    localparam logic [PARAM_W-1:0] SGR_RESET   = 14'd0;
    localparam logic [PARAM_W-1:0] SGR_FG_LO   = 14'd30;
    localparam logic [PARAM_W-1:0] SGR_FG_HI   = 14'd37;
    localparam logic [PARAM_W-1:0] SGR_BG_LO   = 14'd40;
    localparam logic [PARAM_W-1:0] SGR_BG_HI   = 14'd47;
    localparam logic [PARAM_W-1:0] SGR_FG_GREY = 14'd90;

    // colours
    localparam logic [COLOR_W-1:0] COL_FG_RESET = 32'h00FF_FFFF;
    localparam logic [COLOR_W-1:0] COL_BG_RESET = 32'h0000_0000;
    localparam logic [COLOR_W-1:0] COL_WHITE    = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] COL_BLACK    = 32'hFF00_0000;
    localparam logic [COLOR_W-1:0] COL_GREY     = 32'hFF55_5555;

    // result kinds
    localparam logic CMD_DRAW  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    function automatic logic [COLOR_W-1:0] palette(input logic [2:0] idx);
        logic [COLOR_W-1:0] c;
        case (idx)
            3'd0:    c = 32'hFF00_0000;
            3'd1:    c = 32'hFFAA_0000;
            3'd2:    c = 32'hFF00_AA00;
            3'd3:    c = 32'hFFAA_AA00;
            3'd4:    c = 32'hFF00_00AA;
            3'd5:    c = 32'hFFAA_00AA;
            3'd6:    c = 32'hFF00_AAAA;
            default: c = 32'hFFAA_AAAA;
        endcase
        return c;
    endfunction

    // controller to datapath
    typedef struct packed {
        logic cap_char;
        logic csi_start;
        logic digit;
        logic slot_inc;
        logic sgr_start;
        logic sgr_step;
        logic newline;
        logic cret;
        logic bspace;
        logic advance;
        logic h_row;
        logic h_col;
        logic load_glyph;
        logic load_clear;
        logic glyph_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_lbrk;
        logic is_digit;
        logic is_semi;
        logic is_qmark;
        logic is_esc;
        logic is_lf;
        logic is_cr;
        logic is_bs;
        logic is_fin_j;
        logic is_fin_h;
        logic is_fin_m;
        logic p0_is_two;
        logic slot_at_max;
        logic walk_at_slot;
        logic need_clear;
        logic out_free;
    } t_status;

endpackage

>>> design/atce_ctrl.sv
// ----------------------------------------------------------------------------
// atce_ctrl
// escape parser phase and sequencing of one byte through the datapath
// ----------------------------------------------------------------------------
module atce_ctrl
    import atce_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_BOTTOM   = 3'd2;
    localparam logic [2:0] S_EMIT_GLY = 3'd3;
    localparam logic [2:0] S_EMIT_CLR = 3'd4;
    localparam logic [2:0] S_HROW     = 3'd5;
    localparam logic [2:0] S_HCOL     = 3'd6;
    localparam logic [2:0] S_SGR      = 3'd7;

    localparam logic [1:0] PH_TEXT = 2'd0;
    localparam logic [1:0] PH_ESC  = 2'd1;
    localparam logic [1:0] PH_CSI  = 2'd2;

    logic [2:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic       r_gly_pend, n_gly_pend;
    logic       r_need_clr, n_need_clr;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_gly_pend = r_gly_pend;
        n_need_clr = r_need_clr;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap_char = 1'b1;
                    n_state        = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_state = S_IDLE;
                case (r_phase)
                    PH_ESC: begin
                        if (i_status.is_lbrk) begin
                            o_cmd.csi_start = 1'b1;
                            n_phase         = PH_CSI;
                        end else begin
                            n_phase = PH_TEXT;
                        end
                    end
                    PH_CSI: begin
                        if (i_status.is_digit) begin
                            o_cmd.digit = 1'b1;
                        end else if (i_status.is_semi) begin
                            if (i_status.slot_at_max) begin
                                n_phase = PH_TEXT;
                            end else begin
                                o_cmd.slot_inc = 1'b1;
                            end
                        end else if (!i_status.is_qmark) begin
                            n_phase = PH_TEXT;
                            if (i_status.is_fin_j && i_status.p0_is_two) begin
                                n_gly_pend = 1'b0;
                                n_need_clr = 1'b1;
                                n_state    = S_EMIT_CLR;
                            end else if (i_status.is_fin_h) begin
                                n_state = S_HROW;
                            end else if (i_status.is_fin_m) begin
                                o_cmd.sgr_start = 1'b1;
                                n_state         = S_SGR;
                            end
                        end
                    end
                    default: begin
                        n_gly_pend = 1'b0;
                        if (i_status.is_esc) begin
                            n_phase = PH_ESC;
                        end else if (i_status.is_lf) begin
                            o_cmd.newline = 1'b1;
                            n_state       = S_BOTTOM;
                        end else if (i_status.is_cr) begin
                            o_cmd.cret = 1'b1;
                            n_state    = S_BOTTOM;
                        end else if (i_status.is_bs) begin
                            o_cmd.bspace = 1'b1;
                            n_state      = S_BOTTOM;
                        end else begin
                            o_cmd.advance = 1'b1;
                            n_gly_pend    = 1'b1;
                            n_state       = S_BOTTOM;
                        end
                    end
                endcase
            end
            S_BOTTOM: begin
                n_need_clr = i_status.need_clear;
                if (r_gly_pend) begin
                    n_state = S_EMIT_GLY;
                end else if (i_status.need_clear) begin
                    n_state = S_EMIT_CLR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT_GLY: begin
                if (i_status.out_free) begin
                    o_cmd.load_glyph = 1'b1;
                    o_cmd.glyph_last = !r_need_clr;
                    n_state          = r_need_clr ? S_EMIT_CLR : S_IDLE;
                end
            end
            S_EMIT_CLR: begin
                if (i_status.out_free) begin
                    o_cmd.load_clear = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_HROW: begin
                o_cmd.h_row = 1'b1;
                n_state     = S_HCOL;
            end
            S_HCOL: begin
                o_cmd.h_col = 1'b1;
                n_state     = S_IDLE;
            end
            S_SGR: begin
                o_cmd.sgr_step = 1'b1;
                if (i_status.walk_at_slot) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_TEXT;
            r_gly_pend <= 1'b0;
            r_need_clr <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_gly_pend <= n_gly_pend;
            r_need_clr <= n_need_clr;
        end
    end

endmodule

>>> design/atce_datapath.sv
// ----------------------------------------------------------------------------
// atce_datapath
// configuration, cursor, colours, csi parameter store and result register
// ----------------------------------------------------------------------------
module atce_datapath
    import atce_pkg::*;
#(
    parameter int MAX_PARAMS = DEFAULT_MAX_PARAMS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [CHAR_W-1:0]    i_char,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_m_tready,
    output logic                 o_m_tvalid,
    output logic                 o_m_tuser,
    output logic [TDATA_W-1:0]   o_m_tdata,
    output logic                 o_m_tlast
);

    localparam int SLOT_W = $clog2(MAX_PARAMS);
    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(MAX_PARAMS - 1);

    // configuration
    logic [SCALE_W-1:0] r_scale;
    logic [GH_W-1:0]    r_gheight;
    logic [GC_W-1:0]    r_gcount;
    logic [DIM_W-1:0]   r_screen_w;
    logic [DIM_W-1:0]   r_screen_h;
    logic [DIM_W-1:0]   r_top;

    // cursor, colours and parser store
    logic [POS_W-1:0]   r_col, n_col;
    logic [POS_W-1:0]   r_row, n_row;
    logic [POS_W-1:0]   r_hold_x, r_hold_y;
    logic [COLOR_W-1:0] r_fg, n_fg;
    logic [COLOR_W-1:0] r_bg, n_bg;
    logic [PARAM_W-1:0] r_values [MAX_PARAMS];
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  r_walk;
    logic [CHAR_W-1:0]  r_char;

    // result register
    logic               r_out_valid;
    logic               r_out_cmd;
    logic [CHAR_W-1:0]  r_out_glyph;
    logic [POS_W-1:0]   r_out_x, r_out_y;
    logic [COLOR_W-1:0] r_out_fg, r_out_bg;
    logic               r_out_last;

    logic [CELLW_W-1:0] cell_w;
    logic [CELLH_W-1:0] cell_h;
    logic [SLOT_W-1:0]  rd_idx;
    logic [PARAM_W-1:0] rd_val;
    logic [17:0]        acc;
    logic [PARAM_W-1:0] acc_sat;
    logic [POS_W-1:0]   adv_col;
    logic [PARAM_W-1:0] h_row_n, h_col_n;
    logic [22:0]        h_row_px;
    logic [20:0]        h_col_px;
    logic [CHAR_W-1:0]  glyph_sub;
    logic               out_free;

    assign cell_w = {r_scale, 3'b000};
    assign cell_h = CELLH_W'(r_gheight * r_scale);

    assign rd_idx = i_cmd.sgr_step ? r_walk : r_slot;
    assign rd_val = r_values[rd_idx];

    // times ten as shift and add, then add the digit and saturate
    assign acc = {1'b0, rd_val, 3'b000} + {3'b000, rd_val, 1'b0}
               + 18'(r_char - CHAR_ZERO);
    assign acc_sat = (acc > 18'(PARAM_CAP)) ? PARAM_CAP : acc[PARAM_W-1:0];

    assign adv_col = r_col + POS_W'(cell_w);

    assign h_row_n  = (r_values[0] != '0) ? r_values[0] - 14'd1 : '0;
    assign h_col_n  = (r_values[1] != '0) ? r_values[1] - 14'd1 : '0;
    assign h_row_px = 23'(h_row_n * cell_h);
    assign h_col_px = 21'(h_col_n * cell_w);

    assign glyph_sub = ({1'b0, r_char} >= r_gcount) ? CHAR_QMARK : r_char;
    assign out_free  = !r_out_valid || i_m_tready;

    always_comb begin
        o_status.is_lbrk      = (r_char == CHAR_LBRK);
        o_status.is_digit     = (r_char >= CHAR_ZERO) && (r_char <= CHAR_NINE);
        o_status.is_semi      = (r_char == CHAR_SEMI);
        o_status.is_qmark     = (r_char == CHAR_QMARK);
        o_status.is_esc       = (r_char == CHAR_ESC);
        o_status.is_lf        = (r_char == CHAR_LF);
        o_status.is_cr        = (r_char == CHAR_CR);
        o_status.is_bs        = (r_char == CHAR_BS);
        o_status.is_fin_j     = (r_char == CHAR_FIN_J);
        o_status.is_fin_h     = (r_char == CHAR_FIN_H);
        o_status.is_fin_m     = (r_char == CHAR_FIN_M);
        o_status.p0_is_two    = (r_values[0] == PARAM_TWO);
        o_status.slot_at_max  = (r_slot == SLOT_MAX);
        o_status.walk_at_slot = (r_walk == r_slot);
        o_status.need_clear   =
            (({1'b0, r_row} + 25'(cell_h)) > 25'(r_screen_h)) &&
            (15'(r_screen_h) >= (15'(r_top) + 15'(cell_h)));
        o_status.out_free     = out_free;
    end

    // cursor moves
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cmd.newline) begin
            n_col = '0;
            n_row = r_row + POS_W'(cell_h);
        end else if (i_cmd.cret) begin
            n_col = '0;
        end else if (i_cmd.bspace) begin
            if (r_col >= POS_W'(cell_w)) begin
                n_col = r_col - POS_W'(cell_w);
            end
        end else if (i_cmd.advance) begin
            if (adv_col >= POS_W'(r_screen_w)) begin
                n_col = '0;
                n_row = r_row + POS_W'(cell_h);
            end else begin
                n_col = adv_col;
            end
        end else if (i_cmd.h_row) begin
            n_row = POS_W'(r_top) + POS_W'(h_row_px);
        end else if (i_cmd.h_col) begin
            n_col = POS_W'(h_col_px);
        end else if (i_cmd.load_clear) begin
            n_col = '0;
            n_row = POS_W'(r_top);
        end
    end

    // one sgr code per step
    always_comb begin
        n_fg = r_fg;
        n_bg = r_bg;
        if (i_cmd.sgr_step) begin
            if (rd_val == SGR_RESET) begin
                n_fg = COL_WHITE;
                n_bg = COL_BLACK;
            end else if (rd_val >= SGR_FG_LO && rd_val <= SGR_FG_HI) begin
                n_fg = palette(3'(rd_val - SGR_FG_LO));
            end else if (rd_val >= SGR_BG_LO && rd_val <= SGR_BG_HI) begin
                n_bg = palette(3'(rd_val - SGR_BG_LO));
            end else if (rd_val == SGR_FG_GREY) begin
                n_fg = COL_GREY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= RST_FONT_SCALE;
            r_gheight  <= RST_GLYPH_HEIGHT;
            r_gcount   <= RST_GLYPH_COUNT;
            r_screen_w <= RST_SCREEN_W;
            r_screen_h <= RST_SCREEN_H;
            r_top      <= RST_TOP_ROW;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FONT_SCALE:   r_scale    <= i_cfg_data[SCALE_W-1:0];
                REG_GLYPH_HEIGHT: r_gheight  <= i_cfg_data[GH_W-1:0];
                REG_GLYPH_COUNT:  r_gcount   <= i_cfg_data[GC_W-1:0];
                REG_SCREEN_W:     r_screen_w <= i_cfg_data;
                REG_SCREEN_H:     r_screen_h <= i_cfg_data;
                REG_TOP_ROW:      r_top      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= POS_W'(RST_TOP_ROW);
            r_fg   <= COL_FG_RESET;
            r_bg   <= COL_BG_RESET;
            r_slot <= '0;
            r_walk <= '0;
            for (int i = 0; i < MAX_PARAMS; i++) begin
                r_values[i] <= '0;
            end
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_fg  <= n_fg;
            r_bg  <= n_bg;
            if (i_cmd.csi_start) begin
                r_slot <= '0;
                for (int i = 0; i < MAX_PARAMS; i++) begin
                    r_values[i] <= '0;
                end
            end else if (i_cmd.digit) begin
                r_values[r_slot] <= acc_sat;
            end else if (i_cmd.slot_inc) begin
                r_slot <= r_slot + SLOT_W'(1);
            end
            if (i_cmd.sgr_start) begin
                r_walk <= '0;
            end else if (i_cmd.sgr_step) begin
                r_walk <= r_walk + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_char) begin
            r_char <= i_char;
        end
        if (i_cmd.advance) begin
            r_hold_x <= r_col;
            r_hold_y <= r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_glyph || i_cmd.load_clear) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_glyph) begin
            r_out_cmd   <= CMD_DRAW;
            r_out_glyph <= glyph_sub;
            r_out_x     <= r_hold_x;
            r_out_y     <= r_hold_y;
            r_out_fg    <= r_fg;
            r_out_bg    <= r_bg;
            r_out_last  <= i_cmd.glyph_last;
        end else if (i_cmd.load_clear) begin
            r_out_cmd   <= CMD_CLEAR;
            r_out_glyph <= '0;
            r_out_x     <= '0;
            r_out_y     <= POS_W'(r_top);
            r_out_fg    <= r_fg;
            r_out_bg    <= r_bg;
            r_out_last  <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_cmd;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {r_out_bg, r_out_fg, r_out_y, r_out_x, r_out_glyph};

endmodule

>>> design/ansi_text_cursor_engine.sv
// ----------------------------------------------------------------------------
// ansi_text_cursor_engine
// text console cursor engine with an escape sequence parser
// ----------------------------------------------------------------------------
// usage
// - bytes of the text stream arrive on the s_axis request channel, one byte
//   per request; draw and clear commands leave on the m_axis channel
// - each byte gives zero, one or two result requests; tlast marks the final
//   one of a byte, tuser tells a glyph draw (0) from a screen clear (1)
// - the cfg channel writes the six console registers by index and is always
//   ready; the user writes it only while the engine is idle (not enforced)
// - the engine takes one byte at a time; an escape or parameter byte only
//   passes dispatch, a cursor move or glyph also the bottom check (which may
//   add a clear) and a glyph its emit state; an erase-display final goes to
//   the clear emit, cursor placement takes two steps (row, then column) and
//   a colour final walks its n parameters, one parameter a cycle
// - a result is loaded into the output register from its emit state once the
//   register is free; a clear after a glyph is loaded after the glyph
// - the result sits in an output register, so the next byte is taken while
//   it waits; a stalled receiver holds the engine once a further result has
//   to be loaded while the register is still full
// - reset (synchronous, active low) restores the register defaults, puts the
//   cursor at the top left, resets the colours and clears the parser
// ----------------------------------------------------------------------------
`include "ansi_text_cursor_engine_macros.svh"

module ansi_text_cursor_engine
    import atce_pkg::*;
#(
    parameter int MAX_PARAMS = DEFAULT_MAX_PARAMS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte requests
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [CHAR_W-1:0]    s_axis_tdata,   // [7:0] char_code
    // result requests
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // [7:0] glyph, [31:8] pos_x,
                                                 // [55:32] pos_y, [87:56] fg_out,
                                                 // [119:88] bg_out
    output logic                 m_axis_tuser,   // [0] command
    output logic                 m_axis_tlast,
    // register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    // registers can always be written
    assign o_cfg_ready = 1'b1;

    // sequencer: parser phase and per-byte steps
    atce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // cursor, colours, parameters and the result register
    atce_datapath #(
        .MAX_PARAMS (MAX_PARAMS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_char      (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tuser   (m_axis_tuser),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tlast   (m_axis_tlast)
    );

    // one byte in flight: input closes right after a byte is taken
    `ATCE_ASSERT_NEXT(a_one_byte, s_axis_tvalid && s_axis_tready, !s_axis_tready, "byte taken while busy")

    // a clear is always the final result of its byte and starts at column 0
    `ATCE_ASSERT_NOW(a_clear_shape, m_axis_tvalid && (m_axis_tuser == CMD_CLEAR), m_axis_tlast && (m_axis_tdata[31:8] == '0) && (m_axis_tdata[7:0] == '0), "malformed clear result")

endmodule
